// ----- rtl/prrts_pkg.sv -----
// Shared types and constants for the priority round-robin task scheduler.
`timescale 1ns / 1ps
`default_nettype none

package prrts_pkg;

   localparam int REQ_W      = 3;
   localparam int TASK_ID_W  = 16;
   localparam int PRIO_W     = 3;
   localparam int SLOT_IDX_W = 4;
   localparam int STATE_W    = 3;

   localparam logic [PRIO_W-1:0] DESKTOP_PRIO_RESET = 3'd1;

   typedef enum logic [REQ_W-1:0] {
      REQ_YIELD  = 3'd0,
      REQ_CREATE = 3'd1,
      REQ_EXIT   = 3'd2,
      REQ_KILL   = 3'd3,
      REQ_SETP   = 3'd4,
      REQ_READ   = 3'd5
   } req_op_type;

   typedef enum logic [STATE_W-1:0] {
      SLOT_FREE     = 3'd0,
      SLOT_READY    = 3'd1,
      SLOT_RUNNING  = 3'd2,
      SLOT_SLEEPING = 3'd3,
      SLOT_ZOMBIE   = 3'd4,
      SLOT_KILLED   = 3'd5
   } slot_state_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_ZOMBIE,
      WR_OLD_READY,
      WR_NEW_RUN,
      WR_CREATE,
      WR_KILL,
      WR_SETP
   } wr_op_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_DECODE,
      FSM_EXIT_MARK,
      FSM_SCAN,
      FSM_SW_OLD,
      FSM_SW_NEW,
      FSM_WRITE,
      FSM_FINISH
   } fsm_state_type;

   typedef struct packed {
      logic      load;
      logic      scan_start;
      logic      scan_run;
      wr_op_type wr_op;
      logic      emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [REQ_W-1:0] op;
      logic             scan_done;
      logic             found;
      logic             out_free;
   } ctrl_status_type;

endpackage

`default_nettype wire

// ----- rtl/prrts_req_if.sv -----
// Request channel interface of the task scheduler.
`timescale 1ns / 1ps
`default_nettype none

interface prrts_req_if;
   logic                             valid;
   logic                             ready;
   logic [prrts_pkg::REQ_W-1:0]      req_type;
   logic [prrts_pkg::TASK_ID_W-1:0]  task_id;
   logic [prrts_pkg::PRIO_W-1:0]     new_priority;
   logic [prrts_pkg::SLOT_IDX_W-1:0] slot_index;

   modport source (output valid, output req_type, output task_id, output new_priority,
                   output slot_index, input ready);
   modport sink (input valid, input req_type, input task_id, input new_priority,
                 input slot_index, output ready);
endinterface

`default_nettype wire

// ----- rtl/prrts_rsp_if.sv -----
// Response channel interface of the task scheduler.
`timescale 1ns / 1ps
`default_nettype none

interface prrts_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             ok;
   logic [prrts_pkg::TASK_ID_W-1:0]  created_id;
   logic [prrts_pkg::SLOT_IDX_W-1:0] running_slot;
   logic                             switched;
   logic [prrts_pkg::STATE_W-1:0]    read_state;
   logic [prrts_pkg::PRIO_W-1:0]     read_priority;
   logic [prrts_pkg::TASK_ID_W-1:0]  read_id;

   modport source (output valid, output ok, output created_id, output running_slot,
                   output switched, output read_state, output read_priority,
                   output read_id, input ready);
   modport sink (input valid, input ok, input created_id, input running_slot,
                 input switched, input read_state, input read_priority,
                 input read_id, output ready);
endinterface

`default_nettype wire

// ----- rtl/priority_round_robin_task_scheduler_core.sv -----
// Top level of the priority round-robin task scheduler.
//
// Requests arrive on req_ch (valid/ready); each produces one item on rsp_ch.
// The desktop priority is written through csr_wr_en/csr_wr_data and loads
// slot zero's priority at once; the user must write it only while the block
// is idle, as the block itself does not enforce this. One request is in work
// at a time. From acceptance to a valid result a request passes through a
// decode step, a scan of the table memory at one slot per cycle through its
// single read port, the registered read and the end of scan, and a finish
// step. Exit first marks the running slot zombie; on a switch, yield and exit
// write the old slot back to ready if it was running and the new slot to
// running; create writes on success, kill and set priority on a match; read
// scans a single slot, and an unknown type goes straight to the finish step.
// The next request is taken at the earliest in the idle cycle that follows.
// The result sits in an output register: a stalled receiver holds it there
// while the next request is accepted and worked on; that request finishes
// once the register is taken. Reset is synchronous: slot zero ready and the
// running slot at priority 1, other slots free, id counter at 1.
`timescale 1ns / 1ps
`default_nettype none

module priority_round_robin_task_scheduler_core #(
   parameter int SLOTS    = 16,
   parameter int MAX_PRIO = 3,
   parameter int ID_BITS  = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_wr_en,
   input  wire logic [prrts_pkg::PRIO_W-1:0] csr_wr_data,
   prrts_req_if.sink                         req_ch,
   prrts_rsp_if.source                       rsp_ch
);

   prrts_pkg::ctrl_cmd_type    cmd;
   prrts_pkg::ctrl_status_type status;

   prrts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   prrts_datapath #(
      .SLOTS    (SLOTS),
      .MAX_PRIO (MAX_PRIO),
      .ID_BITS  (ID_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .cmd               (cmd),
      .status            (status),
      .req_type          (req_ch.req_type),
      .task_id           (req_ch.task_id),
      .new_priority      (req_ch.new_priority),
      .slot_index        (req_ch.slot_index),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_ok            (rsp_ch.ok),
      .rsp_created_id    (rsp_ch.created_id),
      .rsp_running_slot  (rsp_ch.running_slot),
      .rsp_switched      (rsp_ch.switched),
      .rsp_read_state    (rsp_ch.read_state),
      .rsp_read_priority (rsp_ch.read_priority),
      .rsp_read_id       (rsp_ch.read_id)
   );

endmodule

`default_nettype wire

// ----- rtl/prrts_ctrl.sv -----
// Control state machine of the task scheduler.
`timescale 1ns / 1ps
`default_nettype none

module prrts_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire prrts_pkg::ctrl_status_type status,
   output prrts_pkg::ctrl_cmd_type         cmd
);

   prrts_pkg::fsm_state_type state_ff;
   prrts_pkg::fsm_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= prrts_pkg::FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         prrts_pkg::FSM_IDLE: begin
            if (req_valid) state_in = prrts_pkg::FSM_DECODE;
         end
         prrts_pkg::FSM_DECODE: begin
            case (status.op)
               prrts_pkg::REQ_YIELD, prrts_pkg::REQ_CREATE, prrts_pkg::REQ_KILL,
               prrts_pkg::REQ_SETP, prrts_pkg::REQ_READ: state_in = prrts_pkg::FSM_SCAN;
               prrts_pkg::REQ_EXIT: state_in = prrts_pkg::FSM_EXIT_MARK;
               default: state_in = prrts_pkg::FSM_FINISH;
            endcase
         end
         prrts_pkg::FSM_EXIT_MARK: state_in = prrts_pkg::FSM_SCAN;
         prrts_pkg::FSM_SCAN: begin
            if (status.scan_done) begin
               case (status.op)
                  prrts_pkg::REQ_YIELD, prrts_pkg::REQ_EXIT: begin
                     state_in = status.found ? prrts_pkg::FSM_SW_OLD : prrts_pkg::FSM_FINISH;
                  end
                  prrts_pkg::REQ_CREATE, prrts_pkg::REQ_KILL, prrts_pkg::REQ_SETP: begin
                     state_in = status.found ? prrts_pkg::FSM_WRITE : prrts_pkg::FSM_FINISH;
                  end
                  default: state_in = prrts_pkg::FSM_FINISH;
               endcase
            end
         end
         prrts_pkg::FSM_SW_OLD: state_in = prrts_pkg::FSM_SW_NEW;
         prrts_pkg::FSM_SW_NEW: state_in = prrts_pkg::FSM_FINISH;
         prrts_pkg::FSM_WRITE:  state_in = prrts_pkg::FSM_FINISH;
         prrts_pkg::FSM_FINISH: begin
            if (status.out_free) state_in = prrts_pkg::FSM_IDLE;
         end
         default: state_in = prrts_pkg::FSM_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready      = 1'b0;
      cmd.load       = 1'b0;
      cmd.scan_start = 1'b0;
      cmd.scan_run   = 1'b0;
      cmd.wr_op      = prrts_pkg::WR_NONE;
      cmd.emit       = 1'b0;
      case (state_ff)
         prrts_pkg::FSM_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         prrts_pkg::FSM_DECODE: begin
            case (status.op)
               prrts_pkg::REQ_YIELD, prrts_pkg::REQ_CREATE, prrts_pkg::REQ_KILL,
               prrts_pkg::REQ_SETP, prrts_pkg::REQ_READ: cmd.scan_start = 1'b1;
               default: cmd.scan_start = 1'b0;
            endcase
         end
         prrts_pkg::FSM_EXIT_MARK: begin
            cmd.wr_op      = prrts_pkg::WR_ZOMBIE;
            cmd.scan_start = 1'b1;
         end
         prrts_pkg::FSM_SCAN:   cmd.scan_run = 1'b1;
         prrts_pkg::FSM_SW_OLD: cmd.wr_op = prrts_pkg::WR_OLD_READY;
         prrts_pkg::FSM_SW_NEW: cmd.wr_op = prrts_pkg::WR_NEW_RUN;
         prrts_pkg::FSM_WRITE: begin
            case (status.op)
               prrts_pkg::REQ_CREATE: cmd.wr_op = prrts_pkg::WR_CREATE;
               prrts_pkg::REQ_KILL:   cmd.wr_op = prrts_pkg::WR_KILL;
               prrts_pkg::REQ_SETP:   cmd.wr_op = prrts_pkg::WR_SETP;
               default:               cmd.wr_op = prrts_pkg::WR_NONE;
            endcase
         end
         prrts_pkg::FSM_FINISH: cmd.emit = status.out_free;
         default: req_ready = 1'b0;
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/prrts_datapath.sv -----
// Task table memories, slot scanner and response register of the task scheduler.
`timescale 1ns / 1ps
`default_nettype none

module prrts_datapath #(
   parameter int SLOTS    = 16,
   parameter int MAX_PRIO = 3,
   parameter int ID_BITS  = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_wr_en,
   input  wire logic [prrts_pkg::PRIO_W-1:0]         csr_wr_data,
   input  wire prrts_pkg::ctrl_cmd_type              cmd,
   output prrts_pkg::ctrl_status_type                status,
   input  wire logic [prrts_pkg::REQ_W-1:0]          req_type,
   input  wire logic [prrts_pkg::TASK_ID_W-1:0]      task_id,
   input  wire logic [prrts_pkg::PRIO_W-1:0]         new_priority,
   input  wire logic [prrts_pkg::SLOT_IDX_W-1:0]     slot_index,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic                                      rsp_ok,
   output logic [prrts_pkg::TASK_ID_W-1:0]           rsp_created_id,
   output logic [prrts_pkg::SLOT_IDX_W-1:0]          rsp_running_slot,
   output logic                                      rsp_switched,
   output logic [prrts_pkg::STATE_W-1:0]             rsp_read_state,
   output logic [prrts_pkg::PRIO_W-1:0]              rsp_read_priority,
   output logic [prrts_pkg::TASK_ID_W-1:0]           rsp_read_id
);

   localparam int IDX_W     = $clog2(SLOTS);
   localparam int CNT_W     = $clog2(SLOTS + 1);
   localparam int TID_W     = (ID_BITS < prrts_pkg::TASK_ID_W) ? ID_BITS : prrts_pkg::TASK_ID_W;
   localparam int RUN_OUT_W = (IDX_W < prrts_pkg::SLOT_IDX_W) ? IDX_W : prrts_pkg::SLOT_IDX_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
   localparam logic [prrts_pkg::PRIO_W-1:0] PRIO_CAP = prrts_pkg::PRIO_W'(MAX_PRIO);

   // captured request
   logic [prrts_pkg::REQ_W-1:0]      op_ff;
   logic [ID_BITS-1:0]               tid_ff;
   logic [prrts_pkg::PRIO_W-1:0]     prio_ff;
   logic [prrts_pkg::SLOT_IDX_W-1:0] sidx_ff;

   // table storage
   logic [prrts_pkg::STATE_W-1:0] st_mem_ff [SLOTS];
   logic [prrts_pkg::PRIO_W-1:0]  pr_mem_ff [SLOTS];
   logic [ID_BITS-1:0]            id_mem_ff [SLOTS];
   logic [prrts_pkg::STATE_W-1:0] st_q_ff;
   logic [prrts_pkg::PRIO_W-1:0]  pr_q_ff;
   logic [ID_BITS-1:0]            id_q_ff;
   logic [SLOTS-1:0]              st_vld_ff, pr_vld_ff, id_vld_ff;

   logic [IDX_W-1:0]   run_ff, run_in;
   logic [ID_BITS-1:0] id_cnt_ff, id_cnt_in;

   // scanner
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0] iss_cnt_ff, iss_cnt_in;
   logic [CNT_W-1:0] ev_cnt_ff, ev_cnt_in;
   logic [CNT_W-1:0] len_ff, len_in;
   logic             ev_vld_ff, ev_vld_in;
   logic [IDX_W-1:0] ev_addr_ff;
   logic             issue;

   logic                         found_ff, found_in;
   logic [IDX_W-1:0]             best_ff, best_in;
   logic [prrts_pkg::PRIO_W-1:0] best_prio_ff, best_prio_in;
   logic                         was_run_ff, was_run_in;

   // per-request results
   logic [ID_BITS-1:0]            created_ff, created_in;
   logic                          sw_ff, sw_in;
   logic [prrts_pkg::STATE_W-1:0] rs_ff, rs_in;
   logic [prrts_pkg::PRIO_W-1:0]  rp_ff, rp_in;
   logic [ID_BITS-1:0]            rid_ff, rid_in;
   logic                          ok_now;

   logic                          rsp_valid_ff, rsp_valid_in;

   // table write port
   logic                          st_we, pr_we, id_we;
   logic [IDX_W-1:0]              wr_addr;
   logic [prrts_pkg::STATE_W-1:0] st_wd;
   logic [prrts_pkg::PRIO_W-1:0]  pr_wd;

   logic [prrts_pkg::STATE_W-1:0] ev_state;
   logic [prrts_pkg::PRIO_W-1:0]  ev_prio;
   logic [ID_BITS-1:0]            ev_id;
   logic                          ev_first;
   logic                          in_range;
   logic [prrts_pkg::PRIO_W-1:0]  prio_clamp;

   assign in_range   = (32'(sidx_ff) < 32'(SLOTS));
   assign prio_clamp = (prio_ff > PRIO_CAP) ? PRIO_CAP : prio_ff;
   assign ev_first   = (ev_cnt_ff == '0);

   // entries never written read as their reset contents
   always_comb begin
      if (st_vld_ff[ev_addr_ff]) begin
         ev_state = st_q_ff;
      end else if (ev_addr_ff == '0) begin
         ev_state = prrts_pkg::SLOT_READY;
      end else begin
         ev_state = prrts_pkg::SLOT_FREE;
      end
      if (pr_vld_ff[ev_addr_ff]) begin
         ev_prio = pr_q_ff;
      end else if (ev_addr_ff == '0) begin
         ev_prio = prrts_pkg::DESKTOP_PRIO_RESET;
      end else begin
         ev_prio = '0;
      end
      ev_id = id_vld_ff[ev_addr_ff] ? id_q_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_type;
         tid_ff  <= ID_BITS'(task_id[TID_W-1:0]);
         prio_ff <= new_priority;
         sidx_ff <= slot_index;
      end
   end

   // write port
   always_comb begin
      st_we   = 1'b0;
      pr_we   = 1'b0;
      id_we   = 1'b0;
      wr_addr = best_ff;
      st_wd   = prrts_pkg::SLOT_READY;
      pr_wd   = prio_ff;
      case (cmd.wr_op)
         prrts_pkg::WR_ZOMBIE: begin
            st_we   = 1'b1;
            wr_addr = run_ff;
            st_wd   = prrts_pkg::SLOT_ZOMBIE;
         end
         prrts_pkg::WR_OLD_READY: begin
            // only a task that was running returns to ready
            st_we   = was_run_ff;
            wr_addr = run_ff;
            st_wd   = prrts_pkg::SLOT_READY;
         end
         prrts_pkg::WR_NEW_RUN: begin
            st_we = 1'b1;
            st_wd = prrts_pkg::SLOT_RUNNING;
         end
         prrts_pkg::WR_CREATE: begin
            st_we = 1'b1;
            pr_we = 1'b1;
            id_we = 1'b1;
            st_wd = prrts_pkg::SLOT_READY;
         end
         prrts_pkg::WR_KILL: begin
            st_we = 1'b1;
            st_wd = prrts_pkg::SLOT_KILLED;
         end
         prrts_pkg::WR_SETP: begin
            pr_we = 1'b1;
            pr_wd = prio_clamp;
         end
         default: st_we = 1'b0;
      endcase
      if (csr_wr_en) begin
         pr_we   = 1'b1;
         wr_addr = '0;
         pr_wd   = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (st_we) st_mem_ff[wr_addr] <= st_wd;
      if (pr_we) pr_mem_ff[wr_addr] <= pr_wd;
      if (id_we) id_mem_ff[wr_addr] <= id_cnt_ff;
      st_q_ff <= st_mem_ff[ptr_ff];
      pr_q_ff <= pr_mem_ff[ptr_ff];
      id_q_ff <= id_mem_ff[ptr_ff];
      ev_addr_ff <= ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_vld_ff <= '0;
         pr_vld_ff <= '0;
         id_vld_ff <= '0;
      end else begin
         if (st_we) st_vld_ff[wr_addr] <= 1'b1;
         if (pr_we) pr_vld_ff[wr_addr] <= 1'b1;
         if (id_we) id_vld_ff[wr_addr] <= 1'b1;
      end
   end

   // scanner control
   assign issue = cmd.scan_run && (iss_cnt_ff != len_ff);

   always_comb begin
      ptr_in     = ptr_ff;
      iss_cnt_in = iss_cnt_ff;
      ev_cnt_in  = ev_cnt_ff;
      len_in     = len_ff;
      ev_vld_in  = issue;
      if (cmd.scan_start) begin
         iss_cnt_in = '0;
         ev_cnt_in  = '0;
         case (op_ff)
            prrts_pkg::REQ_YIELD, prrts_pkg::REQ_EXIT: begin
               // slot running first, for its state, then the rest in rotation
               ptr_in = run_ff;
               len_in = CNT_W'(SLOTS);
            end
            prrts_pkg::REQ_CREATE: begin
               ptr_in = IDX_W'(1);
               len_in = CNT_W'(SLOTS - 1);
            end
            prrts_pkg::REQ_KILL, prrts_pkg::REQ_SETP: begin
               ptr_in = '0;
               len_in = CNT_W'(SLOTS);
            end
            prrts_pkg::REQ_READ: begin
               ptr_in = IDX_W'(sidx_ff);
               len_in = CNT_W'(1);
            end
            default: begin
               ptr_in = '0;
               len_in = CNT_W'(1);
            end
         endcase
      end else begin
         if (issue) begin
            ptr_in     = (ptr_ff == LAST_IDX) ? '0 : ptr_ff + 1'b1;
            iss_cnt_in = iss_cnt_ff + 1'b1;
         end
         if (ev_vld_ff) ev_cnt_in = ev_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff     <= '0;
         iss_cnt_ff <= '0;
         ev_cnt_ff  <= '0;
         len_ff     <= '0;
         ev_vld_ff  <= 1'b0;
      end else begin
         ptr_ff     <= ptr_in;
         iss_cnt_ff <= iss_cnt_in;
         ev_cnt_ff  <= ev_cnt_in;
         len_ff     <= len_in;
         ev_vld_ff  <= ev_vld_in;
      end
   end

   // evaluate one returned entry a cycle
   always_comb begin
      found_in     = found_ff;
      best_in      = best_ff;
      best_prio_in = best_prio_ff;
      was_run_in   = was_run_ff;
      rs_in        = rs_ff;
      rp_in        = rp_ff;
      rid_in       = rid_ff;
      if (cmd.load) begin
         rs_in  = '0;
         rp_in  = '0;
         rid_in = '0;
      end
      if (cmd.scan_start) begin
         found_in     = 1'b0;
         best_in      = '0;
         best_prio_in = '0;
         was_run_in   = 1'b0;
      end else if (ev_vld_ff) begin
         case (op_ff)
            prrts_pkg::REQ_YIELD, prrts_pkg::REQ_EXIT: begin
               if (ev_first) begin
                  was_run_in = (ev_state == prrts_pkg::SLOT_RUNNING);
               end else if ((ev_state == prrts_pkg::SLOT_READY) &&
                            (!found_ff || (ev_prio > best_prio_ff))) begin
                  found_in     = 1'b1;
                  best_in      = ev_addr_ff;
                  best_prio_in = ev_prio;
               end
            end
            prrts_pkg::REQ_CREATE: begin
               if (!found_ff && ((ev_state == prrts_pkg::SLOT_FREE) ||
                                 (ev_state == prrts_pkg::SLOT_ZOMBIE))) begin
                  found_in = 1'b1;
                  best_in  = ev_addr_ff;
               end
            end
            prrts_pkg::REQ_KILL, prrts_pkg::REQ_SETP: begin
               if (!found_ff && (ev_state != prrts_pkg::SLOT_FREE) && (ev_id == tid_ff)) begin
                  found_in = 1'b1;
                  best_in  = ev_addr_ff;
               end
            end
            prrts_pkg::REQ_READ: begin
               if (in_range) begin
                  rs_in  = ev_state;
                  rp_in  = ev_prio;
                  rid_in = ev_id;
               end
            end
            default: found_in = found_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      best_ff      <= best_in;
      best_prio_ff <= best_prio_in;
      was_run_ff   <= was_run_in;
      rs_ff        <= rs_in;
      rp_ff        <= rp_in;
      rid_ff       <= rid_in;
   end

   // running slot, id counter, per-request flags
   always_comb begin
      run_in     = run_ff;
      id_cnt_in  = id_cnt_ff;
      created_in = created_ff;
      sw_in      = sw_ff;
      if (cmd.load) begin
         created_in = '0;
         sw_in      = 1'b0;
      end
      case (cmd.wr_op)
         prrts_pkg::WR_NEW_RUN: begin
            run_in = best_ff;
            sw_in  = 1'b1;
         end
         prrts_pkg::WR_CREATE: begin
            created_in = id_cnt_ff;
            id_cnt_in  = id_cnt_ff + 1'b1;
         end
         default: run_in = run_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff    <= '0;
         id_cnt_ff <= ID_BITS'(1);
      end else begin
         run_ff    <= run_in;
         id_cnt_ff <= id_cnt_in;
      end
      created_ff <= created_in;
      sw_ff      <= sw_in;
   end

   always_comb begin
      case (op_ff)
         prrts_pkg::REQ_YIELD, prrts_pkg::REQ_EXIT: ok_now = 1'b1;
         prrts_pkg::REQ_CREATE, prrts_pkg::REQ_KILL, prrts_pkg::REQ_SETP: ok_now = found_ff;
         prrts_pkg::REQ_READ: ok_now = in_range;
         default: ok_now = 1'b0;
      endcase
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.emit) begin
         rsp_ok            <= ok_now;
         rsp_created_id    <= prrts_pkg::TASK_ID_W'(created_ff[TID_W-1:0]);
         rsp_running_slot  <= prrts_pkg::SLOT_IDX_W'(run_ff[RUN_OUT_W-1:0]);
         rsp_switched      <= sw_ff;
         rsp_read_state    <= rs_ff;
         rsp_read_priority <= rp_ff;
         rsp_read_id       <= prrts_pkg::TASK_ID_W'(rid_ff[TID_W-1:0]);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign status.op        = op_ff;
   assign status.scan_done = (ev_cnt_ff == len_ff);
   assign status.found     = found_ff;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

endmodule

`default_nettype wire

// ----- rtl/prrts_checker.sv -----
// Port-level assertions for the task scheduler, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module prrts_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_valid,
   input wire logic                             req_ready,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_ready,
   input wire logic                             rsp_ok,
   input wire logic                             rsp_switched,
   input wire logic [prrts_pkg::TASK_ID_W-1:0]  rsp_created_id,
   input wire logic [prrts_pkg::SLOT_IDX_W-1:0] rsp_running_slot
);

   // hold a stalled item
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response item dropped while stalled");

   // one request in work: no acceptance right after one
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in work");

   // a new result appears only while requests are held off
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("response appeared without a request in work");

   // a failed request neither switches nor hands out an id
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> !rsp_switched && (rsp_created_id == '0))
      else $error("failed request reported a switch or an id");

   // a failed request without a switch keeps the running slot of the last result
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) && $past(rsp_valid, 2) && !rsp_switched && !rsp_ok |->
      (rsp_running_slot == $past(rsp_running_slot, 2)))
      else $error("running slot changed without a switch");

endmodule

bind priority_round_robin_task_scheduler_core prrts_checker u_prrts_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_ok           (rsp_ch.ok),
   .rsp_switched     (rsp_ch.switched),
   .rsp_created_id   (rsp_ch.created_id),
   .rsp_running_slot (rsp_ch.running_slot)
);

`default_nettype wire

// ----- test/priority_round_robin_task_scheduler_core_tb.sv -----
// Self-checking testbench for the priority round-robin task scheduler core.
`timescale 1ns / 1ps

module priority_round_robin_task_scheduler_core_tb;

   localparam int SLOTS         = 16;
   localparam int MAX_PRIO      = 3;
   localparam int ID_BITS       = 16;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 240;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = SLOTS + 8;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int LIVE          = 0;
   localparam int PLAN          = 1;

   localparam logic [prrts_pkg::REQ_W-1:0] OP_UNUSED_6 = 3'd6;
   localparam logic [prrts_pkg::REQ_W-1:0] OP_UNUSED_7 = 3'd7;

   typedef struct packed {
      logic [prrts_pkg::REQ_W-1:0]      op;
      logic [prrts_pkg::TASK_ID_W-1:0]  task_id;
      logic [prrts_pkg::PRIO_W-1:0]     new_priority;
      logic [prrts_pkg::SLOT_IDX_W-1:0] slot_index;
   } sched_req_type;

   typedef struct packed {
      logic                             ok;
      logic [prrts_pkg::TASK_ID_W-1:0]  created_id;
      logic [prrts_pkg::SLOT_IDX_W-1:0] running_slot;
      logic                             switched;
      logic [prrts_pkg::STATE_W-1:0]    read_state;
      logic [prrts_pkg::PRIO_W-1:0]     read_priority;
      logic [prrts_pkg::TASK_ID_W-1:0]  read_id;
   } sched_rsp_type;

   logic                         clock       = 1'b0;
   logic                         reset       = 1'b1;
   logic                         csr_wr_en   = 1'b0;
   logic [prrts_pkg::PRIO_W-1:0] csr_wr_data = '0;

   prrts_req_if req_ch ();
   prrts_rsp_if rsp_ch ();

   priority_round_robin_task_scheduler_core #(
      .SLOTS    (SLOTS),
      .MAX_PRIO (MAX_PRIO),
      .ID_BITS  (ID_BITS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch)
   );

   // Task table copies: LIVE follows accepted items, PLAN runs ahead for stimulus.
   prrts_pkg::slot_state_type       slot_st  [2][SLOTS];
   logic [prrts_pkg::PRIO_W-1:0]    slot_pr  [2][SLOTS];
   logic [prrts_pkg::TASK_ID_W-1:0] slot_tid [2][SLOTS];
   int                              run_slot [2];
   logic [prrts_pkg::TASK_ID_W-1:0] next_tid [2];

   sched_req_type req_backlog [$];
   sched_rsp_type awaited_rsp [$];
   sched_req_type offered;
   sched_rsp_type seen_rsp, due_rsp;

   int   errors      = 0;
   int   rsp_count   = 0;
   int   cycle_count = 0;
   int   idle_odds   = 0;
   int   send_gap    = 0;
   int   recv_gap    = 0;
   int   hold_left   = 0;
   logic hold_req    = 1'b0;
   int   create_run  = 0;
   int   exit_run    = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("priority_round_robin_task_scheduler_core test failed");
         $finish;
      end
   end

   task automatic report(string msg);
      if (errors < 100) $display("ERROR rsp %0d: %s", rsp_count, msg);
      errors++;
   endtask

   // Rotate from the slot after the running one; a strictly higher priority wins.
   function automatic logic yield_to_best(int v);
      int                           idx, best;
      logic                         found;
      logic [prrts_pkg::PRIO_W-1:0] best_pr;
      found   = 1'b0;
      best    = 0;
      best_pr = '0;
      for (int k = 1; k < SLOTS; k++) begin
         idx = (run_slot[v] + k) % SLOTS;
         if (slot_st[v][idx] == prrts_pkg::SLOT_READY &&
             (!found || slot_pr[v][idx] > best_pr)) begin
            found   = 1'b1;
            best    = idx;
            best_pr = slot_pr[v][idx];
         end
      end
      if (!found || best == run_slot[v]) return 1'b0;
      if (slot_st[v][run_slot[v]] == prrts_pkg::SLOT_RUNNING)
         slot_st[v][run_slot[v]] = prrts_pkg::SLOT_READY;
      slot_st[v][best] = prrts_pkg::SLOT_RUNNING;
      run_slot[v] = best;
      return 1'b1;
   endfunction

   function automatic int slot_of_id(int v, logic [prrts_pkg::TASK_ID_W-1:0] id);
      for (int i = 0; i < SLOTS; i++)
         if (slot_st[v][i] != prrts_pkg::SLOT_FREE && slot_tid[v][i] == id) return i;
      return SLOTS;
   endfunction

   function automatic sched_rsp_type run_request(int v, sched_req_type r);
      sched_rsp_type                o;
      int                           s;
      logic [prrts_pkg::PRIO_W-1:0] p;
      o = '0;
      s = SLOTS;
      case (r.op)
         prrts_pkg::REQ_YIELD: begin
            o.switched = yield_to_best(v);
            o.ok = 1'b1;
         end
         prrts_pkg::REQ_CREATE: begin
            for (int i = SLOTS - 1; i >= 1; i--)
               if (slot_st[v][i] == prrts_pkg::SLOT_FREE ||
                   slot_st[v][i] == prrts_pkg::SLOT_ZOMBIE) s = i;
            if (s < SLOTS) begin
               slot_tid[v][s] = next_tid[v];
               slot_st[v][s]  = prrts_pkg::SLOT_READY;
               slot_pr[v][s]  = r.new_priority;
               o.created_id   = next_tid[v];
               next_tid[v]    = next_tid[v] + 1'b1;
               o.ok = 1'b1;
            end
         end
         prrts_pkg::REQ_EXIT: begin
            slot_st[v][run_slot[v]] = prrts_pkg::SLOT_ZOMBIE;
            o.switched = yield_to_best(v);
            o.ok = 1'b1;
         end
         prrts_pkg::REQ_KILL: begin
            s = slot_of_id(v, r.task_id);
            if (s < SLOTS) begin
               slot_st[v][s] = prrts_pkg::SLOT_KILLED;
               o.ok = 1'b1;
            end
         end
         prrts_pkg::REQ_SETP: begin
            p = (r.new_priority > MAX_PRIO) ? prrts_pkg::PRIO_W'(MAX_PRIO) : r.new_priority;
            s = slot_of_id(v, r.task_id);
            if (s < SLOTS) begin
               slot_pr[v][s] = p;
               o.ok = 1'b1;
            end
         end
         prrts_pkg::REQ_READ: begin
            if (int'(r.slot_index) < SLOTS) begin
               o.read_state    = slot_st[v][r.slot_index];
               o.read_priority = slot_pr[v][r.slot_index];
               o.read_id       = slot_tid[v][r.slot_index];
               o.ok = 1'b1;
            end
         end
         default: ;
      endcase
      o.running_slot = prrts_pkg::SLOT_IDX_W'(run_slot[v]);
      return o;
   endfunction

   task automatic add_item(sched_req_type r);
      void'(run_request(PLAN, r));
      req_backlog.push_back(r);
   endtask

   // Mostly well-formed traffic: create bursts, kill-then-exit pairs, ids that exist.
   function automatic sched_req_type make_request();
      sched_req_type r;
      int            pick, s, stuck;
      r.op           = prrts_pkg::REQ_YIELD;
      r.task_id      = prrts_pkg::TASK_ID_W'($urandom);
      r.new_priority = prrts_pkg::PRIO_W'($urandom);
      r.slot_index   = prrts_pkg::SLOT_IDX_W'($urandom);
      s    = $urandom_range(0, SLOTS - 1);
      pick = $urandom_range(0, 99);
      if (create_run > 0) begin
         create_run--;
         r.op = prrts_pkg::REQ_CREATE;
      end else if (exit_run > 0) begin
         exit_run--;
         r.op = prrts_pkg::REQ_EXIT;
      end else if (pick < 3) begin
         create_run = $urandom_range(4, 15);
         r.op = prrts_pkg::REQ_CREATE;
      end else if (pick < 5) begin
         exit_run = $urandom_range(2, 6);
         r.op = prrts_pkg::REQ_EXIT;
      end else if (pick < 30) begin
         r.op = prrts_pkg::REQ_CREATE;
      end else if (pick < 55) begin
         r.op = prrts_pkg::REQ_YIELD;
      end else if (pick < 65) begin
         // spare the desktop slot most of the time
         r.op = (run_slot[PLAN] == 0 && pick < 62) ? prrts_pkg::REQ_YIELD :
                                                     prrts_pkg::REQ_EXIT;
      end else if (pick < 73) begin
         r.op = prrts_pkg::REQ_KILL;
      end else if (pick < 83) begin
         r.op = prrts_pkg::REQ_SETP;
      end else if (pick < 97) begin
         r.op = prrts_pkg::REQ_READ;
      end else begin
         r.op = pick[0] ? OP_UNUSED_6 : OP_UNUSED_7;
      end

      if (r.op == prrts_pkg::REQ_KILL) begin
         // killed slots that are not running never come back; keep them few
         stuck = 0;
         for (int i = 0; i < SLOTS; i++)
            if (slot_st[PLAN][i] == prrts_pkg::SLOT_KILLED && i != run_slot[PLAN]) stuck++;
         pick = $urandom_range(0, 9);
         if (pick < 4) begin
            r.task_id = slot_tid[PLAN][run_slot[PLAN]];
            exit_run  = 1;
         end else if (pick < 7 && stuck < 3) begin
            r.task_id = slot_tid[PLAN][s];
         end
      end else if (r.op == prrts_pkg::REQ_SETP && $urandom_range(0, 9) < 7) begin
         r.task_id = slot_tid[PLAN][s];
      end
      return r;
   endfunction

   // Request driver: hold the item until taken, then predict its result.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) awaited_rsp.push_back(run_request(LIVE, offered));
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_ch.valid <= 1'b0;
            end else if (req_backlog.size() != 0 && $urandom_range(1, 100) <= idle_odds) begin
               send_gap = $urandom_range(0, 16);
               req_ch.valid <= 1'b0;
            end else if (req_backlog.size() != 0) begin
               offered = req_backlog.pop_front();
               req_ch.valid        <= 1'b1;
               req_ch.req_type     <= offered.op;
               req_ch.task_id      <= offered.task_id;
               req_ch.new_priority <= offered.new_priority;
               req_ch.slot_index   <= offered.slot_index;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Response ready: long hold on request, else random stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_req) begin
         hold_req  = 1'b0;
         hold_left = HOLD_CYCLES - 1;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap--;
         rsp_ch.ready <= 1'b0;
      end else if ($urandom_range(1, 100) <= idle_odds) begin
         recv_gap = $urandom_range(0, 16);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         seen_rsp = '{rsp_ch.ok, rsp_ch.created_id, rsp_ch.running_slot, rsp_ch.switched,
                      rsp_ch.read_state, rsp_ch.read_priority, rsp_ch.read_id};
         if (awaited_rsp.size() == 0) begin
            report("item with no request outstanding");
         end else begin
            due_rsp = awaited_rsp.pop_front();
            if (seen_rsp.ok !== due_rsp.ok)
               report($sformatf("ok expected %0d got %0d", due_rsp.ok, seen_rsp.ok));
            if (seen_rsp.created_id !== due_rsp.created_id)
               report($sformatf("created_id expected %0d got %0d",
                                due_rsp.created_id, seen_rsp.created_id));
            if (seen_rsp.running_slot !== due_rsp.running_slot)
               report($sformatf("running_slot expected %0d got %0d",
                                due_rsp.running_slot, seen_rsp.running_slot));
            if (seen_rsp.switched !== due_rsp.switched)
               report($sformatf("switched expected %0d got %0d",
                                due_rsp.switched, seen_rsp.switched));
            if (seen_rsp.read_state !== due_rsp.read_state)
               report($sformatf("read_state expected %0d got %0d",
                                due_rsp.read_state, seen_rsp.read_state));
            if (seen_rsp.read_priority !== due_rsp.read_priority)
               report($sformatf("read_priority expected %0d got %0d",
                                due_rsp.read_priority, seen_rsp.read_priority));
            if (seen_rsp.read_id !== due_rsp.read_id)
               report($sformatf("read_id expected %0d got %0d",
                                due_rsp.read_id, seen_rsp.read_id));
         end
         rsp_count++;
      end
   end

   task automatic wait_drained();
      while (req_backlog.size() != 0 || req_ch.valid || awaited_rsp.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [prrts_pkg::PRIO_W-1:0] setting;
      req_ch.valid        = 1'b0;
      req_ch.req_type     = '0;
      req_ch.task_id      = '0;
      req_ch.new_priority = '0;
      req_ch.slot_index   = '0;
      rsp_ch.ready        = 1'b0;

      for (int i = 0; i < SLOTS; i++) begin
         slot_st[LIVE][i]  = prrts_pkg::SLOT_FREE;
         slot_pr[LIVE][i]  = '0;
         slot_tid[LIVE][i] = '0;
      end
      slot_st[LIVE][0] = prrts_pkg::SLOT_READY;
      slot_pr[LIVE][0] = prrts_pkg::DESKTOP_PRIO_RESET;
      run_slot[LIVE]   = 0;
      next_tid[LIVE]   = 1;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph > 0) begin
            wait_drained();
            setting = (ph == 1) ? prrts_pkg::PRIO_W'(7) :
                      (ph == 2) ? prrts_pkg::PRIO_W'(0) : prrts_pkg::PRIO_W'($urandom);
            csr_wr_en   <= 1'b1;
            csr_wr_data <= setting;
            slot_pr[LIVE][0] = setting;
            @(posedge clock);
            csr_wr_en <= 1'b0;
         end
         slot_st[PLAN]  = slot_st[LIVE];
         slot_pr[PLAN]  = slot_pr[LIVE];
         slot_tid[PLAN] = slot_tid[LIVE];
         run_slot[PLAN] = run_slot[LIVE];
         next_tid[PLAN] = next_tid[LIVE];
         idle_odds = (ph == PHASES - 1) ? 0 : 4 + $urandom_range(0, 3) * 7;

         if (ph == 0) begin
            // nothing ready
            add_item(sched_req_type'{prrts_pkg::REQ_YIELD,  16'h0000, 3'd0, 4'd0});
            add_item(sched_req_type'{prrts_pkg::REQ_READ,   16'h0000, 3'd0, 4'd15});
            // clamped
            add_item(sched_req_type'{prrts_pkg::REQ_SETP,   16'h0000, 3'd7, 4'd0});
            add_item(sched_req_type'{prrts_pkg::REQ_CREATE, 16'h0000, 3'd7, 4'd0});
            add_item(sched_req_type'{prrts_pkg::REQ_YIELD,  16'h0000, 3'd0, 4'd0});
            // running task
            add_item(sched_req_type'{prrts_pkg::REQ_KILL,   16'h0001, 3'd0, 4'd0});
            // no such id
            add_item(sched_req_type'{prrts_pkg::REQ_KILL,   16'hFFFF, 3'd0, 4'd0});
            add_item(sched_req_type'{OP_UNUSED_6, 16'hFFFF, 3'd7, 4'd15});
            add_item(sched_req_type'{OP_UNUSED_7, 16'h0000, 3'd0, 4'd0});
            add_item(sched_req_type'{prrts_pkg::REQ_EXIT,   16'h0000, 3'd0, 4'd0});
            // fill every slot, the last create finds the table full
            for (int i = 0; i < SLOTS; i++)
               add_item(sched_req_type'{prrts_pkg::REQ_CREATE, 16'h0000,
                                        prrts_pkg::PRIO_W'(i), 4'd0});
         end else begin
            if (ph == 2) hold_req = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++) add_item(make_request());
         end
      end

      wait_drained();
      if (errors == 0) begin
         $display("priority_round_robin_task_scheduler_core test passed");
      end else begin
         $display("priority_round_robin_task_scheduler_core test failed");
      end
      $finish;
   end

endmodule
